// ===== rtl/dtti_pkg.sv =====
// dtti_pkg: shared types and the constant sample table of the Delta T interpolator.
// Used by dtti_seq, dtti_dp, dtti_div and delta_t_table_interpolator. No dependencies.
package dtti_pkg;

    // Divider dividend width (covers 4*J + 730 and the linear-term numerator)
    localparam int DIV_W    = 45;
    localparam int DVSR_W   = 17;
    localparam int ROM_SIZE = 58;
    localparam int ROM_IDX_W = $clog2(ROM_SIZE);

    // The two constant divisors: days per 4 years (Q16 year scale) and the linear term scale
    localparam logic [DVSR_W-1:0] YEAR_DIV = 17'd1461;
    localparam logic [DVSR_W-1:0] LIN_DIV  = 17'd100000;

    // Datapath operation selected by the current control word
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_DIV_YEAR,
        OP_DIV_STEP,
        OP_YEAR,
        OP_FB_MUL,
        OP_FB_DIV,
        OP_FB_SUM,
        OP_ROM,
        OP_IP_MUL,
        OP_IP_SUM,
        OP_OUT
    } t_op;

    // Hold on the current step while this condition is true
    typedef enum logic [1:0] {
        W_NONE,
        W_NO_INPUT,
        W_DIV_BUSY,
        W_OUT_BLOCKED
    } t_wcond;

    // Branch to the target step when this condition is true
    typedef enum logic [1:0] {
        J_NEVER,
        J_ALWAYS,
        J_IN_RANGE
    } t_jcond;

    // Which constant divisor a division uses
    typedef enum logic {
        DS_YEAR,
        DS_LIN
    } t_dsel;

    typedef logic [3:0] t_step;

    typedef struct packed {
        t_op    op;
        t_wcond w_cond;
        t_jcond j_cond;
        t_step  target;
    } t_uword;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic no_input;
        logic div_last;
        logic out_blocked;
        logic in_range;
    } t_status;

    // Request to the shared divider
    typedef struct packed {
        logic              load;
        logic              run;
        logic [DIV_W-1:0]  dividend;
        t_dsel             sel;
    } t_div_req;

    // Quarter-year samples in hundredths of a second
    localparam int ROM_HUND [ROM_SIZE] = '{
        6383, 6391, 6398, 6401, 6409, 6416, 6421, 6422,
        6430, 6437, 6441, 6442, 6447, 6453, 6455, 6454,
        6457, 6462, 6465, 6464, 6469, 6476, 6480, 6479,
        6485, 6492, 6499, 6504, 6515, 6525, 6534, 6537,
        6546, 6554, 6561, 6564, 6578, 6586, 6595, 6598,
        6607, 6617, 6624, 6624, 6632, 6639, 6647, 6650,
        6660, 6671, 6679, 6683, 6692, 6698, 6703, 6712,
        6715, 6718
    };

    typedef logic [22:0] t_rom_q16 [ROM_SIZE];

    // Samples converted to Q16 seconds, rounded half up
    function automatic t_rom_q16 rom_build();
        t_rom_q16 r;
        for (int k = 0; k < ROM_SIZE; k++) begin
            r[k] = 23'((ROM_HUND[k] * 65536 + 50) / 100);
        end
        return r;
    endfunction

    localparam t_rom_q16 ROM_Q16 = rom_build();

endpackage

// ===== rtl/dtti_div.sv =====
// dtti_div: shared divider for the two constant divisors, by reciprocal multiplication.
// Four steps per quotient: two partial products, the remainder, one correction.
// Depends on dtti_pkg.
module dtti_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dtti_pkg::t_div_req         i_req,
    output logic [dtti_pkg::DIV_W-1:0] o_quo,
    output logic                       o_last
);
    import dtti_pkg::*;

    localparam int DIV_STEPS = 4;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int LO_W      = 23;
    localparam int RCP_W     = 31;
    localparam int PP_W      = LO_W + RCP_W;
    localparam int Q_W       = 31;
    // Reciprocals floor(2^41 / 1461) and floor(2^45 / 100000); estimate is low by at most one
    localparam logic [RCP_W-1:0] RCP_YEAR = RCP_W'((64'd1 << 41) / 64'(YEAR_DIV));
    localparam logic [RCP_W-1:0] RCP_LIN  = RCP_W'((64'd1 << 45) / 64'(LIN_DIV));
    localparam int SH_YEAR = 41 - LO_W;
    localparam int SH_LIN  = 45 - LO_W;

    // Step codes, counted down from a load
    localparam logic [CNT_W-1:0] ST_LO  = CNT_W'(4);
    localparam logic [CNT_W-1:0] ST_HI  = CNT_W'(3);
    localparam logic [CNT_W-1:0] ST_REM = CNT_W'(2);
    localparam logic [CNT_W-1:0] ST_FIX = CNT_W'(1);

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_dsel             r_sel, n_sel;
    logic [DIV_W-1:0]  r_x, n_x;
    logic [PP_W-1:0]   r_acc, n_acc;
    logic [Q_W-1:0]    r_q, n_q;
    logic [DVSR_W:0]   r_rem, n_rem;

    logic [RCP_W-1:0]  s_rcp;
    logic [DVSR_W-1:0] s_dvsr;
    logic [LO_W-1:0]   s_mop;
    logic [PP_W-1:0]   s_pp;
    logic [PP_W-1:0]   s_sum;
    logic [DIV_W-1:0]  s_qd;

    // Constants of the selected divisor
    assign s_rcp  = (r_sel == DS_YEAR) ? RCP_YEAR : RCP_LIN;
    assign s_dvsr = (r_sel == DS_YEAR) ? YEAR_DIV : LIN_DIV;

    // Dividend times reciprocal, low half then high half
    assign s_mop = (r_cnt == ST_LO) ? r_x[LO_W-1:0] : LO_W'(r_x[DIV_W-1:LO_W]);
    assign s_pp  = PP_W'(s_mop) * PP_W'(s_rcp);
    assign s_sum = (r_acc >> LO_W) + s_pp;

    // Estimate times divisor, for the remainder
    assign s_qd = DIV_W'(r_q) * DIV_W'(s_dvsr);

    always_comb begin
        n_cnt = r_cnt;
        n_sel = r_sel;
        n_x   = r_x;
        n_acc = r_acc;
        n_q   = r_q;
        n_rem = r_rem;
        if (i_req.load) begin
            n_cnt = CNT_W'(DIV_STEPS);
            n_sel = i_req.sel;
            n_x   = i_req.dividend;
        end else if (i_req.run) begin
            n_cnt = r_cnt - 1'b1;
            unique case (r_cnt)
                ST_LO: begin
                    n_acc = s_pp;
                end
                ST_HI: begin
                    n_q = (r_sel == DS_YEAR) ? Q_W'(s_sum >> SH_YEAR) : Q_W'(s_sum >> SH_LIN);
                end
                ST_REM: begin
                    n_rem = (DVSR_W+1)'(r_x - s_qd);
                end
                ST_FIX: begin
                    if (r_rem >= {1'b0, s_dvsr}) begin
                        n_q = r_q + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel <= n_sel;
        r_x   <= n_x;
        r_acc <= n_acc;
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_quo  = DIV_W'(r_q);
    assign o_last = (r_cnt == ST_FIX);

    // A load arms a full count of steps
    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.load |=> r_cnt == CNT_W'(DIV_STEPS))
        else $error("divider count not armed after load");

    // Never stepped once the count is spent
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.run && !i_req.load) |-> r_cnt != '0)
        else $error("divider stepped past its last step");

endmodule

// ===== rtl/dtti_seq.sv =====
// dtti_seq: step counter and microcode table that sequence the datapath.
// Depends on dtti_pkg.
module dtti_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtti_pkg::t_status i_status,
    output dtti_pkg::t_uword  o_uword
);
    import dtti_pkg::*;

    // Step addresses
    localparam t_step S_IDLE  = 4'd0;
    localparam t_step S_YDIV  = 4'd1;
    localparam t_step S_YSTEP = 4'd2;
    localparam t_step S_YEAR  = 4'd3;
    localparam t_step S_FMUL  = 4'd4;
    localparam t_step S_FDIV  = 4'd5;
    localparam t_step S_FSTEP = 4'd6;
    localparam t_step S_FSUM  = 4'd7;
    localparam t_step S_ROM   = 4'd8;
    localparam t_step S_IPMUL = 4'd9;
    localparam t_step S_IPSUM = 4'd10;
    localparam t_step S_OUT   = 4'd11;

    // Microcode program
    function automatic t_uword ucode(input t_step pc);
        t_uword w;
        w = '{op: OP_IDLE, w_cond: W_NONE, j_cond: J_ALWAYS, target: S_IDLE};
        unique case (pc)
            S_IDLE:  w = '{op: OP_IDLE,     w_cond: W_NO_INPUT,    j_cond: J_NEVER,
                           target: S_IDLE};
            S_YDIV:  w = '{op: OP_DIV_YEAR, w_cond: W_NONE,        j_cond: J_NEVER,
                           target: S_IDLE};
            S_YSTEP: w = '{op: OP_DIV_STEP, w_cond: W_DIV_BUSY,    j_cond: J_NEVER,
                           target: S_IDLE};
            S_YEAR:  w = '{op: OP_YEAR,     w_cond: W_NONE,        j_cond: J_IN_RANGE,
                           target: S_ROM};
            S_FMUL:  w = '{op: OP_FB_MUL,   w_cond: W_NONE,        j_cond: J_NEVER,
                           target: S_IDLE};
            S_FDIV:  w = '{op: OP_FB_DIV,   w_cond: W_NONE,        j_cond: J_NEVER,
                           target: S_IDLE};
            S_FSTEP: w = '{op: OP_DIV_STEP, w_cond: W_DIV_BUSY,    j_cond: J_NEVER,
                           target: S_IDLE};
            S_FSUM:  w = '{op: OP_FB_SUM,   w_cond: W_NONE,        j_cond: J_ALWAYS,
                           target: S_OUT};
            S_ROM:   w = '{op: OP_ROM,      w_cond: W_NONE,        j_cond: J_NEVER,
                           target: S_IDLE};
            S_IPMUL: w = '{op: OP_IP_MUL,   w_cond: W_NONE,        j_cond: J_NEVER,
                           target: S_IDLE};
            S_IPSUM: w = '{op: OP_IP_SUM,   w_cond: W_NONE,        j_cond: J_NEVER,
                           target: S_IDLE};
            S_OUT:   w = '{op: OP_OUT,      w_cond: W_OUT_BLOCKED, j_cond: J_ALWAYS,
                           target: S_IDLE};
            default: w = '{op: OP_IDLE,     w_cond: W_NONE,        j_cond: J_ALWAYS,
                           target: S_IDLE};
        endcase
        return w;
    endfunction

    t_step  r_pc, n_pc;
    t_uword s_uword;
    logic   s_w_hit;
    logic   s_j_hit;

    // Output decode: control word of the current step
    always_comb begin
        s_uword = ucode(r_pc);
    end

    // Next step: hold, branch or fall through
    always_comb begin
        unique case (s_uword.w_cond)
            W_NONE:        s_w_hit = 1'b0;
            W_NO_INPUT:    s_w_hit = i_status.no_input;
            W_DIV_BUSY:    s_w_hit = !i_status.div_last;
            W_OUT_BLOCKED: s_w_hit = i_status.out_blocked;
        endcase
        unique case (s_uword.j_cond)
            J_NEVER:    s_j_hit = 1'b0;
            J_ALWAYS:   s_j_hit = 1'b1;
            J_IN_RANGE: s_j_hit = i_status.in_range;
            default:    s_j_hit = 1'b0;
        endcase
        priority if (s_w_hit) begin
            n_pc = r_pc;
        end else if (s_j_hit) begin
            n_pc = s_uword.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = s_uword;

    // Program counter stays inside the program
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= S_OUT)
        else $error("step counter left the program");

    // A divider load is always followed by its step loop
    a_div_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_uword.op == OP_DIV_YEAR || s_uword.op == OP_FB_DIV)
            |=> s_uword.op == OP_DIV_STEP)
        else $error("divider load not followed by step loop");

endmodule

// ===== rtl/dtti_dp.sv =====
// dtti_dp: datapath registers, multipliers, table lookup and output register.
// Depends on dtti_pkg; driven by dtti_seq, uses dtti_div for both divisions.
module dtti_dp #(
    parameter int TABLE_ENTRIES = 58
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dtti_pkg::t_uword           i_uword,
    output dtti_pkg::t_status          o_status,
    output dtti_pkg::t_div_req         o_div_req,
    input  logic [dtti_pkg::DIV_W-1:0] i_div_quo,
    input  logic                       i_div_last,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [21:0]                i_jd_days,
    input  logic [15:0]                i_jd_fraction,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [31:0]         o_delta_t_q16,
    output logic                       o_used_fallback
);
    import dtti_pkg::*;

    // Samples in use, clamped to the table
    localparam int N_USE = (TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE :
                           ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
    localparam int STEP_Q16  = 16384;
    localparam int STEP_SH   = $clog2(STEP_Q16);
    localparam logic signed [30:0] U_LAST = 31'((N_USE - 1) * STEP_Q16);

    localparam logic [DIV_W-1:0]   YEAR_RND  = 45'd730;
    // 4711.96 years in Q16 plus 2000 years in Q16
    localparam logic signed [31:0] YEAR_BIAS = 32'sd439875011;
    localparam logic signed [46:0] C1_Q5     = 47'sd32217;
    localparam logic signed [46:0] LIN_RND   = 47'sd50000;
    localparam logic [57:0]        SQ_RND    = 58'd32768;
    localparam logic [58:0]        C2_Q24    = 59'd93768;
    localparam logic [58:0]        QUAD_RND  = 59'd8388608;
    localparam logic signed [39:0] IP_RND    = 40'sd8192;
    localparam logic signed [37:0] C0_Q16    = 38'sd4123525;
    localparam logic signed [37:0] DT_MAX    = 38'sd2147483647;
    localparam logic signed [37:0] DT_MIN    = -38'sd2147483648;

    logic [37:0]        r_jq, n_jq;
    logic signed [30:0] r_u, n_u;
    logic               r_fallback, n_fallback;
    logic [57:0]        r_mag2, n_mag2;
    logic signed [46:0] r_lnum, n_lnum;
    logic               r_lneg, n_lneg;
    logic [58:0]        r_qprod, n_qprod;
    logic [22:0]        r_lo, n_lo;
    logic [22:0]        r_hi, n_hi;
    logic [14:0]        r_f, n_f;
    logic signed [39:0] r_iprod, n_iprod;
    logic signed [37:0] r_dt, n_dt;
    logic signed [31:0] r_odt, n_odt;
    logic               r_ofb, n_ofb;
    logic               r_ovalid, n_ovalid;

    logic signed [31:0]    s_year32;
    logic signed [30:0]    s_u;
    logic                  s_in_range;
    logic [30:0]           s_mag;
    logic [28:0]           s_m;
    logic [46:0]           s_lmag;
    logic [41:0]           s_sq;
    logic [34:0]           s_quad;
    logic signed [37:0]    s_lin;
    logic [6:0]            s_i;
    logic [ROM_IDX_W-1:0]  s_idx_hi;
    logic [ROM_IDX_W-1:0]  s_idx_lo;
    logic [19:0]           s_f;
    logic signed [23:0]    s_diff;
    logic signed [31:0]    s_sat;
    logic                  s_out_blocked;

    // Year offset from 2000 in Q16 and table span check
    assign s_year32   = $signed({2'b00, i_div_quo[29:0]}) - YEAR_BIAS;
    assign s_u        = s_year32[30:0];
    assign s_in_range = (s_u >= 31'sd0) && (s_u <= U_LAST);

    // Fallback operands
    assign s_mag  = r_u[30] ? 31'(-r_u) : 31'(r_u);
    assign s_m    = s_mag[28:0];
    assign s_lmag = r_lnum[46] ? 47'(-r_lnum) + 47'(LIN_DIV - 1'b1) : 47'(r_lnum);
    assign s_sq   = 42'((r_mag2 + SQ_RND) >> 16);
    assign s_quad = 35'((r_qprod + QUAD_RND) >> 24);
    assign s_lin  = r_lneg ? -$signed({10'd0, i_div_quo[27:0]})
                           : $signed({10'd0, i_div_quo[27:0]});

    // Bracketing samples: hi index is ceil(offset / step)
    assign s_i      = {1'b0, r_u[19:14]} + 7'(r_u[13:0] != '0);
    assign s_idx_hi = s_i[ROM_IDX_W-1:0];
    assign s_idx_lo = (s_i == '0) ? '0 : ROM_IDX_W'(s_i - 1'b1);
    assign s_f      = r_u[19:0] - (20'(s_idx_lo) << STEP_SH);
    assign s_diff   = $signed({1'b0, r_hi}) - $signed({1'b0, r_lo});

    // Saturation to 32 bits
    always_comb begin
        priority if (r_dt > DT_MAX) begin
            s_sat = 32'(DT_MAX);
        end else if (r_dt < DT_MIN) begin
            s_sat = 32'(DT_MIN);
        end else begin
            s_sat = r_dt[31:0];
        end
    end

    assign s_out_blocked = r_ovalid && !i_out_ready;

    // Divider requests
    always_comb begin
        o_div_req.load     = (i_uword.op == OP_DIV_YEAR) || (i_uword.op == OP_FB_DIV);
        o_div_req.run      = (i_uword.op == OP_DIV_STEP);
        o_div_req.dividend = (i_uword.op == OP_DIV_YEAR) ?
                             45'({r_jq, 2'b00}) + YEAR_RND : s_lmag[DIV_W-1:0];
        o_div_req.sel      = (i_uword.op == OP_DIV_YEAR) ? DS_YEAR : DS_LIN;
    end

    // Per-step register updates
    always_comb begin
        n_jq       = r_jq;
        n_u        = r_u;
        n_fallback = r_fallback;
        n_mag2     = r_mag2;
        n_lnum     = r_lnum;
        n_lneg     = r_lneg;
        n_qprod    = r_qprod;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_f        = r_f;
        n_iprod    = r_iprod;
        n_dt       = r_dt;
        n_odt      = r_odt;
        n_ofb      = r_ofb;
        n_ovalid   = r_ovalid && !i_out_ready;
        unique case (i_uword.op)
            OP_IDLE: begin
                if (i_in_valid) begin
                    n_jq = {i_jd_days, i_jd_fraction};
                end
            end
            OP_DIV_YEAR: begin
            end
            OP_DIV_STEP: begin
            end
            OP_YEAR: begin
                n_u        = s_u;
                n_fallback = !s_in_range;
            end
            OP_FB_MUL: begin
                n_mag2 = 58'(s_m) * 58'(s_m);
                n_lnum = 47'(r_u) * C1_Q5 + LIN_RND;
            end
            OP_FB_DIV: begin
                n_qprod = 59'(s_sq) * C2_Q24;
                n_lneg  = r_lnum[46];
            end
            OP_FB_SUM: begin
                n_dt = C0_Q16 + s_lin + $signed({3'd0, s_quad});
            end
            OP_ROM: begin
                n_lo = ROM_Q16[s_idx_lo];
                n_hi = ROM_Q16[s_idx_hi];
                n_f  = s_f[14:0];
            end
            OP_IP_MUL: begin
                n_iprod = 40'(s_diff) * 40'($signed({1'b0, r_f}));
            end
            OP_IP_SUM: begin
                n_dt = $signed({15'd0, r_lo}) + 38'((r_iprod + IP_RND) >>> STEP_SH);
            end
            OP_OUT: begin
                if (!s_out_blocked) begin
                    n_odt    = s_sat;
                    n_ofb    = r_fallback;
                    n_ovalid = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_jq       <= n_jq;
        r_u        <= n_u;
        r_fallback <= n_fallback;
        r_mag2     <= n_mag2;
        r_lnum     <= n_lnum;
        r_lneg     <= n_lneg;
        r_qprod    <= n_qprod;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_f        <= n_f;
        r_iprod    <= n_iprod;
        r_dt       <= n_dt;
        r_odt      <= n_odt;
        r_ofb      <= n_ofb;
    end

    // Status and ports
    always_comb begin
        o_status.no_input    = !i_in_valid;
        o_status.div_last    = i_div_last;
        o_status.out_blocked = s_out_blocked;
        o_status.in_range    = s_in_range;
    end

    // No item is taken while reset is held
    assign o_in_ready      = (i_uword.op == OP_IDLE) && i_rst_n;
    assign o_out_valid     = r_ovalid;
    assign o_delta_t_q16   = r_odt;
    assign o_used_fallback = r_ofb;

    // Table path only runs for years inside the span
    a_rom_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_uword.op == OP_ROM) |-> !r_fallback)
        else $error("table lookup for a year outside the span");

    // Interpolated value lies between its two samples
    a_ip_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_uword.op == OP_OUT && !r_fallback) |->
            ((r_dt >= $signed({15'd0, r_lo}) && r_dt <= $signed({15'd0, r_hi})) ||
             (r_dt <= $signed({15'd0, r_lo}) && r_dt >= $signed({15'd0, r_hi}))))
        else $error("interpolation outside bracketing samples");

    // A result handed over is presented on the next cycle
    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_uword.op == OP_OUT && !s_out_blocked) |=> r_ovalid)
        else $error("result not presented after output step");

endmodule

// ===== rtl/delta_t_table_interpolator.sv =====
// delta_t_table_interpolator: top level, Julian date to TT minus UT in Q16 seconds.
// Depends on dtti_pkg, dtti_seq, dtti_dp and dtti_div.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_ready   i_jd_days[21:0], i_jd_fraction[15:0]
//   output    out        o_out_valid / i_out_ready o_delta_t_q16[31:0], o_used_fallback
//
// One item at a time. A date inside the table span reaches the result register through a
// 4-step reciprocal division for the year, then lookup and interpolation; a date outside
// goes through two divisions on the shared divider.
// The next item is taken the cycle after the result has moved into the output register;
// the output step holds while the register is full and i_out_ready is low.
// Synchronous active-low reset returns the sequencer to idle and clears the output valid.
module delta_t_table_interpolator #(
    parameter int TABLE_ENTRIES = 58
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [21:0]        i_jd_days,
    input  logic [15:0]        i_jd_fraction,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_delta_t_q16,
    output logic               o_used_fallback
);
    import dtti_pkg::*;

    t_uword           s_uword;
    t_status          s_status;
    t_div_req         s_div_req;
    logic [DIV_W-1:0] s_div_quo;
    logic             s_div_last;

    // Microcode sequencer
    dtti_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (s_status),
        .o_uword  (s_uword)
    );

    // Datapath
    dtti_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_uword         (s_uword),
        .o_status        (s_status),
        .o_div_req       (s_div_req),
        .i_div_quo       (s_div_quo),
        .i_div_last      (s_div_last),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_jd_days       (i_jd_days),
        .i_jd_fraction   (i_jd_fraction),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_delta_t_q16   (o_delta_t_q16),
        .o_used_fallback (o_used_fallback)
    );

    // Shared divider
    dtti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_div_req),
        .o_quo   (s_div_quo),
        .o_last  (s_div_last)
    );

endmodule
